// ----- sv/mbd_pkg.sv -----
package mbd_pkg;

  localparam int MAX_BUTTONS_DEF = 8;
  localparam int TIME_BITS_DEF   = 32;
  localparam int INPUT_BITS      = 8;
  localparam int OUT_TIME_BITS   = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BUTTONS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd1;

  // per-button debounce states
  localparam logic [1:0] ST_UP      = 2'd0;
  localparam logic [1:0] ST_FALLING = 2'd1;
  localparam logic [1:0] ST_DOWN    = 2'd2;
  localparam logic [1:0] ST_RISING  = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0] fsm;
    logic [1:0] ev;
  } btn_ctl_t;

endpackage

// ----- sv/mbd_if.sv -----
interface mbd_in_if import mbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [INPUT_BITS-1:0]    button_bits;
  logic [OUT_TIME_BITS-1:0] now_ms;

  modport source (output valid, button_bits, now_ms, input ready);
  modport sink   (input valid, button_bits, now_ms, output ready);
endinterface

interface mbd_out_if import mbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               button_index;
  logic [1:0]               button_state;
  logic [1:0]               event_flag;
  logic [OUT_TIME_BITS-1:0] held_ms;
  logic                     last;

  modport source (output valid, button_index, button_state, event_flag, held_ms, last,
                  input ready);
  modport sink   (input valid, button_index, button_state, event_flag, held_ms, last,
                  output ready);
endinterface

// ----- sv/mbd_state_mem.sv -----
module mbd_state_mem import mbd_pkg::*; #(
  parameter int NB    = MAX_BUTTONS_DEF,
  parameter int TB    = TIME_BITS_DEF,
  parameter int IDX_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output btn_ctl_t         rd_ctl_o,
  output logic [TB-1:0]    rd_press_o,
  output logic [TB-1:0]    rd_held_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  btn_ctl_t         wr_ctl_i,
  input  logic [TB-1:0]    wr_press_i,
  input  logic [TB-1:0]    wr_held_i
);

  localparam int EW = $bits(btn_ctl_t) + 2 * TB;

  logic [EW-1:0] mem [NB];
  logic [NB-1:0] vld_q;
  logic [EW-1:0] rdata_q;
  logic          rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_ctl_i, wr_press_i, wr_held_i};
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // an entry never written reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    if (rvld_q) begin
      {rd_ctl_o, rd_press_o, rd_held_o} = rdata_q;
    end else begin
      rd_ctl_o.fsm = ST_UP;
      rd_ctl_o.ev  = EV_NONE;
      rd_press_o   = '0;
      rd_held_o    = '0;
    end
  end

endmodule

// ----- sv/mbd_step.sv -----
module mbd_step import mbd_pkg::*; #(
  parameter int TB = TIME_BITS_DEF
) (
  input  btn_ctl_t      ctl_i,
  input  logic [TB-1:0] press_i,
  input  logic [TB-1:0] held_i,
  input  logic          pressed_i,
  input  logic [TB-1:0] now_i,
  output btn_ctl_t      ctl_o,
  output logic [TB-1:0] press_o,
  output logic [TB-1:0] held_o
);

  always_comb begin
    ctl_o   = ctl_i;
    press_o = press_i;
    held_o  = held_i;
    case (ctl_i.fsm)
      ST_UP: begin
        ctl_o.ev = EV_NONE;
        if (pressed_i) begin
          ctl_o.fsm = ST_FALLING;
        end
      end
      ST_FALLING: begin
        if (pressed_i) begin
          ctl_o.fsm = ST_DOWN;
          ctl_o.ev  = EV_PRESS;
          press_o   = now_i;
        end else begin
          ctl_o.fsm = ST_UP;
        end
      end
      ST_DOWN: begin
        if (!pressed_i) begin
          ctl_o.fsm = ST_RISING;
        end
      end
      default: begin
        if (!pressed_i) begin
          ctl_o.fsm = ST_UP;
          ctl_o.ev  = EV_RELEASE;
          // wraps at the time width
          held_o    = now_i - press_i;
        end else begin
          ctl_o.fsm = ST_DOWN;
        end
      end
    endcase
  end

endmodule

// ----- sv/multi_button_debouncer.sv -----
// Channel   Dir  Payload                                            Handshake
// req_i     in   button_bits, now_ms                                valid/ready
// rsp_o     out  button_index, button_state, event_flag, held_ms,   valid/ready
//                last
// cfg       in   cfg_idx_i, cfg_data_i                              cfg_we_i
//
// A sample with n enabled buttons is taken in the idle state; the state memory
// entry of the first button is then read, and the read-modify-write of each
// entry overlaps the read of the next. With n = 0 no result follows.
// The single state memory port pair sets this overlap.
// Reset clears all buttons to up with zero times through per-entry valid bits.
// A stalled result holds the sequencer in place; one result register parts
// the two sides.
module multi_button_debouncer import mbd_pkg::*; #(
  parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mbd_in_if.sink                req_i,
  mbd_out_if.source             rsp_o
);

  localparam int NB    = (MAX_BUTTONS < INPUT_BITS) ? MAX_BUTTONS : INPUT_BITS;
  localparam int IDX_W = (NB > 1) ? $clog2(NB) : 1;
  localparam int CNT_W = $clog2(NB + 1);
  localparam int TB    = TIME_BITS;
  localparam logic [CFG_DATA_W-1:0] NB_CAP = CFG_DATA_W'(NB);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [1:0]            seq_q, seq_d;
  logic [CFG_DATA_W-1:0] num_q;
  logic                  plvl_q;
  logic [NB-1:0]         bits_q;
  logic [TB-1:0]         now_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      b_q, b_d;

  logic                  out_vld_q;
  logic [2:0]            out_idx_q;
  btn_ctl_t              out_ctl_q;
  logic [TB-1:0]         out_held_q;
  logic                  out_last_q;

  logic                  accept;
  logic [CFG_DATA_W-1:0] n_act;
  logic [63:0]           now_ext;
  logic                  slot_free;
  logic                  adv;
  logic                  is_last;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  btn_ctl_t              rd_ctl, nx_ctl;
  logic [TB-1:0]         rd_press, rd_held, nx_press, nx_held;
  logic [63:0]           held_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      plvl_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_BUTTONS:   num_q  <= cfg_data_i;
        CFG_PRESSED_LEVEL: plvl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = (seq_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign n_act       = (num_q > NB_CAP) ? NB_CAP : num_q;
  assign now_ext     = 64'(req_i.now_ms);
  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign adv         = (seq_q == S_CALC) && slot_free;
  assign is_last     = (CNT_W'(b_q) + CNT_W'(1)) == cnt_q;

  always_comb begin
    seq_d   = seq_q;
    b_d     = b_q;
    rd_en   = 1'b0;
    rd_addr = b_q;
    case (seq_q)
      S_IDLE: begin
        if (accept) begin
          b_d   = '0;
          seq_d = (n_act != '0) ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        rd_en = 1'b1;
        seq_d = S_CALC;
      end
      S_CALC: begin
        if (adv) begin
          if (is_last) begin
            seq_d = S_IDLE;
          end else begin
            // fetch the next entry while this one is written back
            b_d     = b_q + IDX_W'(1);
            rd_en   = 1'b1;
            rd_addr = b_d;
          end
        end
      end
      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= S_IDLE;
      b_q       <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      b_q   <= b_d;
      if (accept) begin
        cnt_q <= CNT_W'(n_act);
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q <= req_i.button_bits[NB-1:0];
      now_q  <= now_ext[TB-1:0];
    end
    if (adv) begin
      out_idx_q  <= 3'(b_q);
      out_ctl_q  <= nx_ctl;
      out_held_q <= nx_held;
      out_last_q <= is_last;
    end
  end

  mbd_state_mem #(
    .NB    (NB),
    .TB    (TB),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_ctl_o   (rd_ctl),
    .rd_press_o (rd_press),
    .rd_held_o  (rd_held),
    .wr_en_i    (adv),
    .wr_addr_i  (b_q),
    .wr_ctl_i   (nx_ctl),
    .wr_press_i (nx_press),
    .wr_held_i  (nx_held)
  );

  mbd_step #(
    .TB (TB)
  ) u_step (
    .ctl_i     (rd_ctl),
    .press_i   (rd_press),
    .held_i    (rd_held),
    .pressed_i (bits_q[b_q] == plvl_q),
    .now_i     (now_q),
    .ctl_o     (nx_ctl),
    .press_o   (nx_press),
    .held_o    (nx_held)
  );

  assign held_ext           = 64'(out_held_q);
  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.button_index = out_idx_q;
  assign rsp_o.button_state = out_ctl_q.fsm;
  assign rsp_o.event_flag   = out_ctl_q.ev;
  assign rsp_o.held_ms      = held_ext[OUT_TIME_BITS-1:0];
  assign rsp_o.last         = out_last_q;

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> (CNT_W'(b_q) < cnt_q))
    else $error("write-back beyond the enabled buttons");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_last |=> seq_q == S_IDLE)
    else $error("sequencer busy after last button");

  a_press_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && rd_ctl.fsm == ST_FALLING && nx_ctl.ev == EV_PRESS |-> nx_ctl.fsm == ST_DOWN)
    else $error("press confirmed outside down state");

  a_release_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && nx_ctl.ev == EV_RELEASE && rd_ctl.fsm == ST_RISING |-> nx_ctl.fsm == ST_UP)
    else $error("release confirmed outside up state");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |=> out_vld_q && $stable(out_idx_q))
    else $error("pending result overwritten");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import mbd_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_SAMPLES = 105;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [1:0]      cidx;
    logic [3:0]      cdata;
    logic [7:0]      bits;
    logic [31:0]     now;
    bit              typed;
    logic [1:0]      st;
    logic [1:0]      ev;
    logic [31:0]     held;
  } stim_row_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [1:0]  st;
    logic [1:0]  ev;
    logic [31:0] held;
    logic        last;
  } btn_res_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [3:0] cfg_data_i;

  mbd_in_if  req_if ();
  mbd_out_if rsp_if ();

  multi_button_debouncer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // debounce model state
  logic [3:0]  mdl_nbtn;
  logic        mdl_plevel;
  logic [1:0]  mdl_fsm   [8];
  logic [1:0]  mdl_ev    [8];
  logic [31:0] mdl_press [8];
  logic [31:0] mdl_held  [8];
  btn_res_t    step_res  [8];

  btn_res_t  btn_expect_q [$];
  stim_row_t stim_tab [$];

  int  errors;
  int  n_samples;
  int  n_checked;
  int  n_press;
  int  n_release;
  int  n_settings;
  bit  calm;
  int  stall_cnt;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("multi_button_debouncer test failed");
    $finish;
  end

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int debounce_step(input logic [7:0] bits, input logic [31:0] now);
    int  n;
    bit  hit;
    n = (mdl_nbtn > 8) ? 8 : int'(mdl_nbtn);
    for (int b = 0; b < n; b++) begin
      hit = (bits[b] == mdl_plevel);
      case (mdl_fsm[b])
        ST_UP: begin
          mdl_ev[b] = EV_NONE;
          if (hit) mdl_fsm[b] = ST_FALLING;
        end
        ST_FALLING: begin
          if (hit) begin
            mdl_fsm[b]   = ST_DOWN;
            mdl_ev[b]    = EV_PRESS;
            mdl_press[b] = now;
          end else begin
            mdl_fsm[b] = ST_UP;
          end
        end
        ST_DOWN: begin
          if (!hit) mdl_fsm[b] = ST_RISING;
        end
        default: begin
          if (!hit) begin
            mdl_fsm[b]  = ST_UP;
            mdl_ev[b]   = EV_RELEASE;
            mdl_held[b] = now - mdl_press[b];
          end else begin
            mdl_fsm[b] = ST_DOWN;
          end
        end
      endcase
      step_res[b].idx  = 3'(b);
      step_res[b].st   = mdl_fsm[b];
      step_res[b].ev   = mdl_ev[b];
      step_res[b].held = mdl_held[b];
      step_res[b].last = (b + 1 == n);
    end
    return n;
  endfunction

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic void cfg_row(input logic [1:0] idx, input logic [3:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind  = ROW_CFG;
    r.cidx  = idx;
    r.cdata = data;
    stim_tab.push_back(r);
  endfunction

  function automatic void smp_row(input logic [7:0] bits, input logic [31:0] now,
                                  input bit typed, input logic [1:0] st,
                                  input logic [1:0] ev, input logic [31:0] held);
    stim_row_t r;
    r = '{kind: ROW_SAMPLE, default: '0};
    r.kind  = ROW_SAMPLE;
    r.bits  = bits;
    r.now   = now;
    r.typed = typed;
    r.st    = st;
    r.ev    = ev;
    r.held  = held;
    stim_tab.push_back(r);
  endfunction

  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_sample(input logic [7:0] bits, input logic [31:0] now, input bit typed,
                             input logic [1:0] st, input logic [1:0] ev,
                             input logic [31:0] held);
    int gap;
    int n;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.button_bits <= bits;
    req_if.now_ms      <= now;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n = debounce_step(bits, now);
    // pin button 0 to the hand-worked value where one is given
    if (typed && n > 0) begin
      step_res[0].st   = st;
      step_res[0].ev   = ev;
      step_res[0].held = held;
    end
    for (int b = 0; b < n; b++) btn_expect_q.push_back(step_res[b]);
    n_samples++;
  endtask

  // Drop valid, wait for every result, then let the sequencer settle.
  task automatic drain_all();
    req_if.valid <= 1'b0;
    while (btn_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [3:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_NUM_BUTTONS) mdl_nbtn = data;
    else if (idx == CFG_PRESSED_LEVEL) mdl_plevel = data[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random back-pressure per result
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) stall_cnt = draw_wait();
    if (stall_cnt > 0) begin
      rsp_if.ready <= 1'b0;
      stall_cnt--;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    btn_res_t e;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (btn_expect_q.size() == 0) begin
        report($sformatf("unexpected result for button %0d", rsp_if.button_index));
      end else begin
        e = btn_expect_q.pop_front();
        n_checked++;
        if (e.ev == EV_PRESS && e.st == ST_DOWN) n_press++;
        if (e.ev == EV_RELEASE && e.st == ST_UP) n_release++;
        if (rsp_if.button_index !== e.idx)
          report($sformatf("button_index %0d, want %0d", rsp_if.button_index, e.idx));
        if (rsp_if.button_state !== e.st)
          report($sformatf("button %0d state %0d, want %0d", e.idx, rsp_if.button_state,
                           e.st));
        if (rsp_if.event_flag !== e.ev)
          report($sformatf("button %0d event %0d, want %0d", e.idx, rsp_if.event_flag,
                           e.ev));
        if (rsp_if.held_ms !== e.held)
          report($sformatf("button %0d held_ms %0h, want %0h", e.idx, rsp_if.held_ms,
                           e.held));
        if (rsp_if.last !== e.last)
          report($sformatf("button %0d last %0b, want %0b", e.idx, rsp_if.last, e.last));
      end
    end
  end

  initial begin
    logic [7:0]  lvl;
    logic [31:0] now;
    logic [3:0]  nb;
    logic        pl;
    int          rand_items;
    int          phase;
    int          per_phase;
    int          r;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.button_bits = '0;
    req_if.now_ms      = '0;
    rsp_if.ready       = 1'b0;
    stall_cnt          = 0;
    calm               = 1'b0;
    errors             = 0;
    n_samples          = 0;
    n_checked          = 0;
    n_press            = 0;
    n_release          = 0;
    n_settings         = 0;

    mdl_nbtn   = 4'd0;
    mdl_plevel = 1'b1;
    for (int b = 0; b < 8; b++) begin
      mdl_fsm[b]   = ST_UP;
      mdl_ev[b]    = EV_NONE;
      mdl_press[b] = '0;
      mdl_held[b]  = '0;
    end

    // nothing enabled after reset
    smp_row(8'hFF, 32'd0, 1'b0, ST_UP, EV_NONE, 32'd0);
    cfg_row(CFG_NUM_BUTTONS, 4'd1);
    smp_row(8'h00, 32'd5,  1'b1, ST_UP,      EV_NONE,    32'd0);
    smp_row(8'h01, 32'd10, 1'b1, ST_FALLING, EV_NONE,    32'd0);
    // bounce back before confirmation
    smp_row(8'h00, 32'd11, 1'b1, ST_UP,      EV_NONE,    32'd0);
    smp_row(8'h01, 32'd20, 1'b1, ST_FALLING, EV_NONE,    32'd0);
    smp_row(8'h01, 32'd30, 1'b1, ST_DOWN,    EV_PRESS,   32'd0);
    smp_row(8'h00, 32'd40, 1'b1, ST_RISING,  EV_PRESS,   32'd0);
    smp_row(8'h01, 32'd41, 1'b1, ST_DOWN,    EV_PRESS,   32'd0);
    smp_row(8'h00, 32'd50, 1'b1, ST_RISING,  EV_PRESS,   32'd0);
    smp_row(8'h00, 32'd80, 1'b1, ST_UP,      EV_RELEASE, 32'd50);
    smp_row(8'h00, 32'd90, 1'b1, ST_UP,      EV_NONE,    32'd50);
    cfg_row(CFG_NUM_BUTTONS, 4'd8);
    cfg_row(2'd2, 4'hF);
    cfg_row(2'd3, 4'h5);
    // press just before the time stamp wraps, release after it
    smp_row(8'hFF, 32'hFFFF_FFF0, 1'b1, ST_FALLING, EV_NONE,    32'd50);
    smp_row(8'hFF, 32'hFFFF_FFF8, 1'b1, ST_DOWN,    EV_PRESS,   32'd50);
    smp_row(8'h00, 32'd3,         1'b1, ST_RISING,  EV_PRESS,   32'd50);
    smp_row(8'h00, 32'd7,         1'b1, ST_UP,      EV_RELEASE, 32'd15);
    cfg_row(CFG_NUM_BUTTONS, 4'd15);
    smp_row(8'hAA, 32'd100, 1'b0, ST_UP, EV_NONE, 32'd0);
    smp_row(8'h55, 32'd200, 1'b0, ST_UP, EV_NONE, 32'd0);
    cfg_row(CFG_PRESSED_LEVEL, 4'b1110);
    smp_row(8'h00, 32'd300,        1'b0, ST_UP, EV_NONE, 32'd0);
    smp_row(8'h00, 32'd310,        1'b0, ST_UP, EV_NONE, 32'd0);
    smp_row(8'hFF, 32'hFFFF_FFFF,  1'b0, ST_UP, EV_NONE, 32'd0);
    smp_row(8'hFF, 32'h0000_0000,  1'b0, ST_UP, EV_NONE, 32'd0);
    cfg_row(CFG_NUM_BUTTONS, 4'd0);
    smp_row(8'h5A, 32'hA5A5_5A5A, 1'b0, ST_UP, EV_NONE, 32'd0);
    cfg_row(CFG_NUM_BUTTONS, 4'd3);
    cfg_row(CFG_PRESSED_LEVEL, 4'b0001);
    smp_row(8'h5A, 32'd1234, 1'b0, ST_UP, EV_NONE, 32'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        drain_all();
        cfg_write(stim_tab[i].cidx, stim_tab[i].cdata);
        n_settings++;
      end else begin
        send_sample(stim_tab[i].bits, stim_tab[i].now, stim_tab[i].typed,
                    stim_tab[i].st, stim_tab[i].ev, stim_tab[i].held);
      end
    end

    // random phases: levels mostly hold for runs so presses get confirmed
    rand_items = 0;
    phase      = 0;
    lvl        = 8'(~mdl_plevel ? 8'hFF : 8'h00);
    now        = $urandom;
    while (rand_items < RAND_SAMPLES) begin
      case (phase)
        0:       begin nb = 4'd8;  pl = 1'b1; end
        1:       begin nb = 4'd1;  pl = 1'b0; end
        2:       begin nb = 4'd0;  pl = 1'($urandom_range(0, 1)); end
        3:       begin nb = 4'd15; pl = 1'($urandom_range(0, 1)); end
        default: begin nb = 4'($urandom_range(1, 15)); pl = 1'($urandom_range(0, 1)); end
      endcase
      drain_all();
      cfg_write(CFG_NUM_BUTTONS, nb);
      cfg_write(CFG_PRESSED_LEVEL, {3'($urandom_range(0, 7)), pl});
      if (phase % 3 == 2) cfg_write(2'($urandom_range(2, 3)), 4'($urandom_range(0, 15)));
      n_settings++;
      calm = (phase % 4 == 1);
      if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FF00 + 32'($urandom_range(0, 200));
      per_phase = (nb == 0) ? 3 : 15;
      for (int k = 0; k < per_phase; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          lvl = 8'($urandom);
        end else begin
          for (int b = 0; b < 8; b++)
            if ($urandom_range(0, 99) < 22) lvl[b] = ~lvl[b];
        end
        r = $urandom_range(0, 99);
        if (r < 85)      now = now + 32'($urandom_range(1, 60));
        else if (r < 95) now = now + $urandom;
        else             now = $urandom;
        send_sample(lvl, now, 1'b0, ST_UP, EV_NONE, 32'd0);
        if (nb != 0) rand_items++;
      end
      phase++;
    end
    calm = 1'b0;

    drain_all();
    $display("ran %0d samples over %0d register settings", n_samples, n_settings);
    $display("checked %0d button results: %0d held down with a press flag, %0d releases",
             n_checked, n_press, n_release);
    if (errors == 0) begin
      $display("multi_button_debouncer test passed");
    end else begin
      $display("multi_button_debouncer test failed");
    end
    $finish;
  end

endmodule
